// File: hdl/kcl_pkg.sv
// ----------------------------------------------------------------------------
// kcl_pkg: shared types and codes for the keypad code lock
// Event codes, register indexes, field widths and the structs that pass
// configuration and results between the lock core and the top level.
// ----------------------------------------------------------------------------
package kcl_pkg;

  localparam int DigitW   = 4;
  localparam int TickW    = 16;
  localparam int EventW   = 3;
  localparam int CountW   = 2;
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 16;
  localparam int InDataW  = 8;
  localparam int OutDataW = 8;

  // Event codes
  localparam logic [EventW-1:0] EV_NONE    = 3'd0;
  localparam logic [EventW-1:0] EV_DIGIT   = 3'd1;
  localparam logic [EventW-1:0] EV_UNLOCK  = 3'd2;
  localparam logic [EventW-1:0] EV_WRONG   = 3'd3;
  localparam logic [EventW-1:0] EV_RELOCK  = 3'd4;
  localparam logic [EventW-1:0] EV_IGNORED = 3'd5;

  // Request kinds
  localparam logic FUNC_TICK = 1'b0;
  localparam logic FUNC_KEY  = 1'b1;

  // Register indexes
  localparam logic [CfgIdxW-1:0] REG_SECRET_FIRST  = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_SECRET_SECOND = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_SECRET_THIRD  = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_SECRET_FOURTH = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_RELOCK_DELAY  = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_LOCKOUT       = 3'd5;

  // Reset values of the registers
  localparam logic [DigitW-1:0] SECRET_FIRST_RST  = 4'd1;
  localparam logic [DigitW-1:0] SECRET_SECOND_RST = 4'd2;
  localparam logic [DigitW-1:0] SECRET_THIRD_RST  = 4'd3;
  localparam logic [DigitW-1:0] SECRET_FOURTH_RST = 4'd4;
  localparam logic [TickW-1:0]  RELOCK_DELAY_RST  = 16'd5000;
  localparam logic [TickW-1:0]  LOCKOUT_RST       = 16'd2000;

  localparam logic [DigitW-1:0] DIGIT_MIN = 4'd1;
  localparam logic [DigitW-1:0] DIGIT_MAX = 4'd9;
  localparam logic [CountW-1:0] LAST_SLOT = 2'd3;
  localparam logic [TickW-1:0]  TICK_MAX  = 16'hFFFF;

  typedef struct packed {
    logic [DigitW-1:0] secret_first;
    logic [DigitW-1:0] secret_second;
    logic [DigitW-1:0] secret_third;
    logic [DigitW-1:0] secret_fourth;
    logic [TickW-1:0]  relock_delay;
    logic [TickW-1:0]  lockout_ticks;
  } kcl_cfg_t;

  typedef struct packed {
    logic [CountW-1:0] digits_held;
    logic              led_level;
    logic              bolt_open;
    logic              is_locked;
    logic [EventW-1:0] event_code;
  } kcl_result_t;

endpackage

// File: hdl/kcl_core.sv
// ----------------------------------------------------------------------------
// kcl_core: lock state and per-request update
// Holds the lock state, computes the result of the request presented and
// commits the new state when step is high.
// ----------------------------------------------------------------------------
module kcl_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          step,
  input  logic                          func,
  input  logic [kcl_pkg::DigitW-1:0]    key_digit,
  input  kcl_pkg::kcl_cfg_t             cfg,
  output kcl_pkg::kcl_result_t          result
);
  import kcl_pkg::*;

  logic              locked_flag;
  logic              locked_flag_next;
  logic [DigitW-1:0] entered_digits [3];
  logic [CountW-1:0] entry_count;
  logic [CountW-1:0] entry_count_next;
  logic [TickW-1:0]  since_entry;
  logic [TickW-1:0]  since_entry_next;
  logic [TickW-1:0]  lockout;
  logic [TickW-1:0]  lockout_next;
  logic              led_state;
  logic              led_state_next;
  logic              store_digit;
  logic [EventW-1:0] event_code;
  logic              digit_ok;
  logic              code_match;
  logic [TickW-1:0]  since_inc;

  assign digit_ok   = (key_digit >= DIGIT_MIN) && (key_digit <= DIGIT_MAX);
  assign code_match = (entered_digits[0] == cfg.secret_first)
                   && (entered_digits[1] == cfg.secret_second)
                   && (entered_digits[2] == cfg.secret_third)
                   && (key_digit == cfg.secret_fourth);
  assign since_inc  = (since_entry == TICK_MAX) ? since_entry : since_entry + 1'b1;

  // Work out the next state and the event for this request
  always_comb begin
    locked_flag_next = locked_flag;
    entry_count_next = entry_count;
    since_entry_next = since_entry;
    lockout_next     = lockout;
    led_state_next   = led_state;
    store_digit      = 1'b0;
    event_code       = EV_NONE;
    if (func == FUNC_TICK) begin
      lockout_next     = (lockout != '0) ? lockout - 1'b1 : lockout;
      since_entry_next = since_inc;
      if (!locked_flag && (since_inc >= cfg.relock_delay)) begin
        locked_flag_next = 1'b1;
        led_state_next   = ~led_state;
        event_code       = EV_RELOCK;
      end
    end else if ((lockout != '0) || !digit_ok) begin
      event_code = EV_IGNORED;
    end else if (entry_count != LAST_SLOT) begin
      store_digit      = 1'b1;
      entry_count_next = entry_count + 1'b1;
      event_code       = EV_DIGIT;
    end else begin
      if (code_match && locked_flag) begin
        locked_flag_next = 1'b0;
        led_state_next   = ~led_state;
        event_code       = EV_UNLOCK;
      end else begin
        lockout_next = cfg.lockout_ticks;
        event_code   = EV_WRONG;
      end
      entry_count_next = '0;
      since_entry_next = '0;
    end
  end

  assign result.event_code  = event_code;
  assign result.is_locked   = locked_flag_next;
  assign result.bolt_open   = ~locked_flag_next;
  assign result.led_level   = led_state_next;
  assign result.digits_held = entry_count_next;

  // Commit control state
  always_ff @(posedge clk) begin
    if (rst) begin
      locked_flag <= 1'b1;
      entry_count <= '0;
      since_entry <= '0;
      lockout     <= '0;
      led_state   <= 1'b1;
    end else if (step) begin
      locked_flag <= locked_flag_next;
      entry_count <= entry_count_next;
      since_entry <= since_entry_next;
      lockout     <= lockout_next;
      led_state   <= led_state_next;
    end
  end

  // Store an entered digit; slots are read only after being written
  always_ff @(posedge clk) begin
    if (step && store_digit) begin
      entered_digits[entry_count] <= key_digit;
    end
  end

endmodule

// File: hdl/keypad_code_lock_controller_unit.sv
// ----------------------------------------------------------------------------
// keypad_code_lock_controller_unit: four-digit keypad code lock
// Takes key presses and millisecond ticks, returns one status result each.
// ----------------------------------------------------------------------------
// Each request (a tick, or a key press with its digit) yields exactly one
// result carrying the event and the lock status after that request. The
// block takes one request per clock cycle unless the output stalls; a
// request waits in the input register, is evaluated by the lock core and
// lands in the result register, which presents its result on m_tvalid
// until the output side takes it. Back-pressure on the output stalls the
// input register and then s_tready. Configuration registers are written
// through cfg_we/cfg_index/cfg_data and must only be changed while no
// request is in flight.
module keypad_code_lock_controller_unit (
  input  logic                            clk,
  input  logic                            rst,
  // Input stream
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [kcl_pkg::InDataW-1:0]     s_tdata,   // [3:0] key_digit, [7:4] zero
  input  logic                            s_tuser,   // [0] func (0 tick, 1 key)
  // Result stream
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [kcl_pkg::OutDataW-1:0]    m_tdata,   // [2:0] event_code, [3] is_locked,
                                                     // [4] bolt_open, [5] led_level,
                                                     // [7:6] digits_held
  // Configuration write port
  input  logic                            cfg_we,
  input  logic [kcl_pkg::CfgIdxW-1:0]     cfg_index,
  input  logic [kcl_pkg::CfgDataW-1:0]    cfg_data
);
  import kcl_pkg::*;

  kcl_cfg_t          cfg;
  logic              in_valid;
  logic              in_func;
  logic [DigitW-1:0] in_digit;
  logic              out_free;
  logic              step;
  kcl_result_t       result;
  kcl_result_t       out_result;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.secret_first  <= SECRET_FIRST_RST;
      cfg.secret_second <= SECRET_SECOND_RST;
      cfg.secret_third  <= SECRET_THIRD_RST;
      cfg.secret_fourth <= SECRET_FOURTH_RST;
      cfg.relock_delay  <= RELOCK_DELAY_RST;
      cfg.lockout_ticks <= LOCKOUT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SECRET_FIRST:  cfg.secret_first  <= cfg_data[DigitW-1:0];
        REG_SECRET_SECOND: cfg.secret_second <= cfg_data[DigitW-1:0];
        REG_SECRET_THIRD:  cfg.secret_third  <= cfg_data[DigitW-1:0];
        REG_SECRET_FOURTH: cfg.secret_fourth <= cfg_data[DigitW-1:0];
        REG_RELOCK_DELAY:  cfg.relock_delay  <= cfg_data[TickW-1:0];
        REG_LOCKOUT:       cfg.lockout_ticks <= cfg_data[TickW-1:0];
        default: ;
      endcase
    end
  end

  // Pipeline handshake: result register frees when empty or being taken
  assign out_free = !m_tvalid || m_tready;
  assign step     = in_valid && out_free;
  assign s_tready = !in_valid || out_free;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_func  <= s_tuser;
      in_digit <= s_tdata[DigitW-1:0];
    end
  end

  kcl_core u_core (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .func      (in_func),
    .key_digit (in_digit),
    .cfg       (cfg),
    .result    (result)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_free) begin
      m_tvalid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_result <= result;
    end
  end

  assign m_tdata = out_result;

endmodule

// File: hdl/kcl_checker.sv
// ----------------------------------------------------------------------------
// kcl_checker: port-level checks for the keypad code lock
// Watches the result stream and flags inconsistent lock status reports.
// ----------------------------------------------------------------------------
module kcl_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         m_tvalid,
  input logic                         m_tready,
  input logic [kcl_pkg::OutDataW-1:0] m_tdata
);
  import kcl_pkg::*;

  kcl_result_t res;
  assign res = m_tdata;

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  // Bolt drive mirrors the lock flag
  a_bolt: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (res.bolt_open == !res.is_locked))
    else $error("bolt drive disagrees with lock flag");

  // Unlock leaves the safe open, relock leaves it shut
  a_lock_event: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (res.event_code == EV_UNLOCK || res.event_code == EV_RELOCK)
      |-> (res.is_locked == (res.event_code == EV_RELOCK)))
    else $error("lock flag disagrees with event");

  // A completed entry clears the digit count
  a_entry_clear: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (res.event_code == EV_UNLOCK || res.event_code == EV_WRONG)
      |-> (res.digits_held == '0))
    else $error("digit count not cleared after entry");

  // Only defined event codes appear
  a_event_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (res.event_code <= EV_IGNORED))
    else $error("undefined event code");

endmodule

bind keypad_code_lock_controller_unit kcl_checker u_kcl_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

// File: test/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: testbench for keypad_code_lock_controller_unit
// Streams ticks and key presses into the lock and checks every status
// result against an in-bench model of the lock, field by field. Runs
// directed cases, a back-pressure burst, random entry sessions across
// changing settings and a maximum-length lockout at the end.
// ----------------------------------------------------------------------------
module tb_top;
  import kcl_pkg::*;

  localparam int HOLD_OFF_CYCLES = 48;
  localparam int RANDOM_TARGET   = 330;
  localparam int RECONFIG_EVERY  = 50;
  localparam int DRAIN_CYCLES    = 8;
  localparam int RUN_LIMIT_NS    = 2_000_000;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [InDataW-1:0]  s_tdata = '0;
  logic                s_tuser = 1'b0;
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [OutDataW-1:0] m_tdata;
  logic                cfg_we = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index = '0;
  logic [CfgDataW-1:0] cfg_data = '0;

  // Lock model state and its copy of the settings
  logic                lock_closed;
  logic [DigitW-1:0]   digit_store [3];
  logic [CountW-1:0]   held_count;
  logic [TickW-1:0]    ticks_since_entry;
  logic [TickW-1:0]    lockout_left;
  logic                led_on;
  logic [DigitW-1:0]   code_digit [4];
  logic [TickW-1:0]    relock_delay;
  logic [TickW-1:0]    lockout_len;

  kcl_result_t         expected_status_q [$];

  // Stimulus controls and run statistics
  bit                  valid_up       = 1'b0;
  bit                  sender_gaps_on = 1'b1;
  bit                  sink_gaps_on   = 1'b1;
  bit                  hold_off_req   = 1'b0;
  int                  requests_sent  = 0;
  int                  useful_sent    = 0;
  int                  results_checked = 0;
  int                  mismatch_count = 0;
  int                  unlock_seen    = 0;
  int                  wrong_seen     = 0;
  int                  relock_seen    = 0;
  int                  ignored_seen   = 0;
  int                  setting_writes = 0;

  always #1 clk = ~clk;

  keypad_code_lock_controller_unit dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Pick an idle length: mostly none, often short, now and then long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Advance the lock model by one request and return the status it yields
  function automatic kcl_result_t lock_predict(logic kind, logic [DigitW-1:0] digit);
    kcl_result_t r;
    logic [EventW-1:0] ev;
    logic hit;
    ev = EV_NONE;
    if (kind == FUNC_TICK) begin
      if (lockout_left != '0) lockout_left = lockout_left - 1'b1;
      if (ticks_since_entry != TICK_MAX) ticks_since_entry = ticks_since_entry + 1'b1;
      if (!lock_closed && ticks_since_entry >= relock_delay) begin
        lock_closed = 1'b1;
        led_on      = ~led_on;
        ev          = EV_RELOCK;
      end
    end else if (lockout_left != '0 || digit < DIGIT_MIN || digit > DIGIT_MAX) begin
      ev = EV_IGNORED;
    end else if (held_count < LAST_SLOT) begin
      digit_store[held_count] = digit;
      held_count = held_count + 1'b1;
      ev = EV_DIGIT;
    end else begin
      hit = digit_store[0] == code_digit[0] && digit_store[1] == code_digit[1] &&
            digit_store[2] == code_digit[2] && digit == code_digit[3];
      if (hit && lock_closed) begin
        lock_closed = 1'b0;
        led_on      = ~led_on;
        ev          = EV_UNLOCK;
      end else begin
        lockout_left = lockout_len;
        ev           = EV_WRONG;
      end
      held_count        = '0;
      ticks_since_entry = '0;
    end
    r.event_code  = ev;
    r.is_locked   = lock_closed;
    r.bolt_open   = ~lock_closed;
    r.led_level   = led_on;
    r.digits_held = held_count;
    return r;
  endfunction

  // Offer one request, hold it until taken, then log its expected status
  task automatic send_request(input logic kind, input logic [DigitW-1:0] digit);
    int gap;
    kcl_result_t want;
    gap = sender_gaps_on ? pick_gap() : 0;
    @(negedge clk);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= kind;
    s_tdata  <= {{(InDataW-DigitW){1'b0}}, digit};
    valid_up = 1'b1;
    do @(posedge clk); while (!s_tready);
    want = lock_predict(kind, digit);
    expected_status_q.push_back(want);
    requests_sent++;
    if (want.event_code != EV_IGNORED) useful_sent++;
  endtask

  task automatic send_tick();
    send_request(FUNC_TICK, DigitW'($urandom_range(0, 15)));
  endtask

  task automatic send_key(input logic [DigitW-1:0] digit);
    send_request(FUNC_KEY, digit);
  endtask

  task automatic enter_digits(input logic [DigitW-1:0] a, input logic [DigitW-1:0] b,
                              input logic [DigitW-1:0] c, input logic [DigitW-1:0] d);
    send_key(a);
    send_key(b);
    send_key(c);
    send_key(d);
  endtask

  task automatic send_tick_run(input int count);
    repeat (count) send_tick();
  endtask

  // Drop the input and wait until every result is back and the pipe is empty
  task automatic wait_idle();
    if (valid_up) begin
      @(negedge clk);
      s_tvalid <= 1'b0;
      valid_up = 1'b0;
    end
    while (expected_status_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Write one setting while idle and mirror it into the model
  task automatic write_register(input logic [CfgIdxW-1:0] index,
                                input logic [CfgDataW-1:0] value);
    wait_idle();
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= index;
    cfg_data  <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    setting_writes++;
    case (index)
      REG_SECRET_FIRST:  code_digit[0] = value[DigitW-1:0];
      REG_SECRET_SECOND: code_digit[1] = value[DigitW-1:0];
      REG_SECRET_THIRD:  code_digit[2] = value[DigitW-1:0];
      REG_SECRET_FOURTH: code_digit[3] = value[DigitW-1:0];
      REG_RELOCK_DELAY:  relock_delay  = value;
      REG_LOCKOUT:       lockout_len   = value;
      default: ;
    endcase
  endtask

  // Run out any lockout and any half-typed entry so the next entry lines up
  task automatic clear_attempt();
    while (lockout_left != '0 || held_count != '0) begin
      if (lockout_left != '0) send_tick();
      else send_key(DIGIT_MIN);
    end
  endtask

  function automatic logic [DigitW-1:0] random_digit();
    return DigitW'($urandom_range(DIGIT_MIN, DIGIT_MAX));
  endfunction

  task automatic write_random_settings();
    int r;
    for (int i = 0; i < 4; i++) begin
      if ($urandom_range(0, 19) == 0)
        write_register(CfgIdxW'(i), CfgDataW'($urandom_range(0, 15)));
      else
        write_register(CfgIdxW'(i), CfgDataW'(random_digit()));
    end
    r = $urandom_range(0, 19);
    if (r == 0) write_register(REG_RELOCK_DELAY, '0);
    else if (r == 1) write_register(REG_RELOCK_DELAY, TICK_MAX);
    else if (r == 2) write_register(REG_RELOCK_DELAY, 16'd1);
    else write_register(REG_RELOCK_DELAY, CfgDataW'($urandom_range(1, 40)));
    if ($urandom_range(0, 4) == 0) write_register(REG_LOCKOUT, '0);
    else write_register(REG_LOCKOUT, CfgDataW'($urandom_range(1, 12)));
  endtask

  // Compare one field and report a difference
  function automatic void check_field(string name, int want, int got);
    if (want != got) begin
      mismatch_count++;
      $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
    end
  endfunction

  // Check each result against the oldest expected status
  always @(posedge clk) begin : result_check
    kcl_result_t got;
    kcl_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      got = kcl_result_t'(m_tdata);
      if (expected_status_q.size() == 0) begin
        mismatch_count++;
        $display("%0t: result with none expected, expected nothing actual %h", $time, m_tdata);
      end else begin
        want = expected_status_q.pop_front();
        results_checked++;
        check_field("event_code", int'(want.event_code), int'(got.event_code));
        check_field("is_locked", int'(want.is_locked), int'(got.is_locked));
        check_field("bolt_open", int'(want.bolt_open), int'(got.bolt_open));
        check_field("led_level", int'(want.led_level), int'(got.led_level));
        check_field("digits_held", int'(want.digits_held), int'(got.digits_held));
        case (want.event_code)
          EV_UNLOCK:  unlock_seen++;
          EV_WRONG:   wrong_seen++;
          EV_RELOCK:  relock_seen++;
          EV_IGNORED: ignored_seen++;
          default: ;
        endcase
      end
    end
  end

  // Drive the result ready with random stalls and the requested long hold-off
  initial begin : result_sink
    int len;
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        len = HOLD_OFF_CYCLES;
      end else begin
        len = sink_gaps_on ? pick_gap() : 0;
      end
      if (len > 0) begin
        m_tready <= 1'b0;
        repeat (len) @(negedge clk);
      end
      m_tready <= 1'b1;
    end
  end

  // Reset settings, entries, ignored keys, wrong code while open, zero lockout and relock
  task automatic test_directed_cases();
    send_tick();
    enter_digits(4'd1, 4'd2, 4'd3, 4'd4);
    send_key(4'd0);
    send_key(4'd15);

    write_register(REG_LOCKOUT, 16'd3);
    write_register(REG_RELOCK_DELAY, TICK_MAX);
    write_register(REG_SECRET_FIRST, CfgDataW'(DIGIT_MAX));
    write_register(REG_SECRET_SECOND, CfgDataW'(DIGIT_MIN));
    write_register(REG_SECRET_THIRD, CfgDataW'(DIGIT_MAX));
    write_register(REG_SECRET_FOURTH, CfgDataW'(DIGIT_MIN));
    enter_digits(4'd5, 4'd5, 4'd5, 4'd5);
    send_key(DIGIT_MAX);
    send_tick_run(3);

    // Correct code while already open counts as wrong; no lockout follows
    write_register(REG_LOCKOUT, '0);
    enter_digits(DIGIT_MAX, DIGIT_MIN, DIGIT_MAX, DIGIT_MIN);
    write_register(REG_RELOCK_DELAY, 16'd1);
    send_tick();

    // Secret digit out of key range can never match
    write_register(REG_RELOCK_DELAY, '0);
    write_register(REG_SECRET_FIRST, 16'd15);
    enter_digits(DIGIT_MAX, DIGIT_MIN, DIGIT_MAX, DIGIT_MIN);
    write_register(REG_SECRET_FIRST, CfgDataW'(DIGIT_MAX));
    enter_digits(DIGIT_MAX, DIGIT_MIN, DIGIT_MAX, DIGIT_MIN);
    send_tick();
  endtask

  // Keep offering requests back to back while the sink holds off
  task automatic test_back_pressure();
    wait_idle();
    write_register(REG_LOCKOUT, 16'd2);
    write_register(REG_RELOCK_DELAY, 16'd6);
    sender_gaps_on = 1'b0;
    hold_off_req   = 1'b1;
    repeat (24) send_request(1'($urandom_range(0, 1)), DigitW'($urandom_range(0, 15)));
    sender_gaps_on = 1'b1;
  endtask

  // Mostly aligned code entries, some wrong codes, noise and partial entries
  task automatic test_random_sessions();
    int start;
    int next_reconfig;
    int kind;
    start = requests_sent;
    next_reconfig = requests_sent;
    while (requests_sent - start < RANDOM_TARGET) begin
      if (requests_sent >= next_reconfig) begin
        write_random_settings();
        next_reconfig  = requests_sent + RECONFIG_EVERY;
        sender_gaps_on = $urandom_range(0, 3) != 0;
        sink_gaps_on   = $urandom_range(0, 3) != 0;
      end
      kind = $urandom_range(0, 9);
      case (kind) inside
        [0:4]: begin
          clear_attempt();
          enter_digits(code_digit[0], code_digit[1], code_digit[2], code_digit[3]);
          send_tick_run($urandom_range(0, 12));
        end
        [5:6]: begin
          clear_attempt();
          enter_digits(random_digit(), random_digit(), random_digit(), random_digit());
          send_tick_run($urandom_range(0, 12));
        end
        7: begin
          repeat ($urandom_range(1, 6))
            send_request(1'($urandom_range(0, 1)), DigitW'($urandom_range(0, 15)));
        end
        8: begin
          repeat ($urandom_range(1, 3)) send_key(random_digit());
          if ($urandom_range(0, 1) == 1) send_key(DigitW'($urandom_range(10, 15)));
          else send_key(4'd0);
        end
        default: send_tick_run($urandom_range(0, 45));
      endcase
    end
    sender_gaps_on = 1'b1;
    sink_gaps_on   = 1'b1;
  endtask

  // Longest lockout: keys stay ignored after a wrong code
  task automatic test_long_lockout();
    wait_idle();
    write_register(REG_LOCKOUT, TICK_MAX);
    clear_attempt();
    enter_digits((code_digit[0] == DIGIT_MAX) ? DIGIT_MIN : DIGIT_MAX,
                 random_digit(), random_digit(), random_digit());
    repeat (3) send_key(random_digit());
    send_tick_run(3);
    send_key(random_digit());
  endtask

  initial begin : main_sequence
    lock_closed       = 1'b1;
    held_count        = '0;
    ticks_since_entry = '0;
    lockout_left      = '0;
    led_on            = 1'b1;
    code_digit[0]     = SECRET_FIRST_RST;
    code_digit[1]     = SECRET_SECOND_RST;
    code_digit[2]     = SECRET_THIRD_RST;
    code_digit[3]     = SECRET_FOURTH_RST;
    relock_delay      = RELOCK_DELAY_RST;
    lockout_len       = LOCKOUT_RST;
    for (int i = 0; i < 3; i++) digit_store[i] = '0;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_directed_cases();
    test_back_pressure();
    test_random_sessions();
    test_long_lockout();

    wait_idle();
    $display("Covered %0d requests (%0d acted on) and %0d checked results, %0d setting writes.",
             requests_sent, useful_sent, results_checked, setting_writes);
    $display("Events seen: %0d unlocks, %0d wrong codes, %0d relocks, %0d ignored keys.",
             unlock_seen, wrong_seen, relock_seen, ignored_seen);
    if (mismatch_count == 0 && expected_status_q.size() == 0) begin
      $display("keypad_code_lock_controller_unit: match");
    end else begin
      $display("keypad_code_lock_controller_unit: mismatch");
    end
    $finish;
  end

  // Stop a hung run
  initial begin : run_limit
    #(RUN_LIMIT_NS);
    $display("keypad_code_lock_controller_unit: mismatch");
    $finish;
  end

endmodule
